@@ rtl/core/assert_macros.svh @@
// Assertion macros for the waypoint generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define CBWG_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An antecedent in one cycle implies a consequent in the same cycle.
`define CBWG_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/core/cbwg_pkg.sv @@
// Shared types, widths and constants of the cubic Bezier waypoint generator.
`default_nettype none

package cbwg_pkg;

  localparam int COORD_W = 32;
  localparam int EXT_W   = COORD_W + 1;
  localparam int STEP_W  = 17;
  localparam int IDX_W   = 2;

  localparam int MAX_POINTS_DEF = 64;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH    = 2;

  localparam int IN_DATA_W  = 6 * COORD_W;
  localparam int OUT_DATA_W = 3 * COORD_W;

  localparam logic [STEP_W-1:0]         STEP_RESET   = 17'd6554;
  localparam logic signed [COORD_W-1:0] SIDE_RESET   = 32'sd13107;
  localparam logic signed [COORD_W-1:0] HEIGHT_RESET = 32'sd19661;

  localparam logic [IDX_W-1:0] REG_STEP   = 2'd0;
  localparam logic [IDX_W-1:0] REG_SIDE   = 2'd1;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

  // Coordinates widened by one bit so a negated extreme extension stays exact.
  typedef logic signed [EXT_W-1:0] ext_coord_t;

  // One classified request: start, shared inner control point, and goal.
  typedef struct packed {
    ext_coord_t p0x;
    ext_coord_t p0y;
    ext_coord_t p0z;
    ext_coord_t p1x;
    ext_coord_t p1y;
    ext_coord_t p1z;
    ext_coord_t pgx;
    ext_coord_t pgy;
    ext_coord_t pgz;
  } desc_t;

endpackage

`default_nettype wire

@@ rtl/core/cbwg_queue.sv @@
// Short descriptor queue between the classifier and the curve engine.
`default_nettype none

module cbwg_queue
  import cbwg_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  wire   push_valid,
  output logic  push_ready,
  input  desc_t push_desc,
  output logic  head_valid,
  output desc_t head_desc,
  input  wire   pop
);

  // Depth is a power of two so the pointers wrap on their own.
  localparam int AW = $clog2(QUEUE_DEPTH);

  desc_t          mem [QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != (AW + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_desc  = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + AW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + AW'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + (AW + 1)'(1);
        2'b01:   count <= count - (AW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_desc;
  end

endmodule

`default_nettype wire

@@ rtl/core/cbwg_front.sv @@
// Request classifier: registers a request and picks the inner control point.
`default_nettype none

module cbwg_front
  import cbwg_pkg::*;
(
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire  [IN_DATA_W-1:0]       in_data,
  input  wire  signed [COORD_W-1:0]  side_ext,
  input  wire  signed [COORD_W-1:0]  height_ext,
  output logic                       push_valid,
  input  wire                        push_ready,
  output desc_t                      push_desc
);

  function automatic logic [COORD_W-1:0] abs_diff(logic signed [COORD_W-1:0] a,
                                                  logic signed [COORD_W-1:0] b);
    logic signed [EXT_W-1:0] d;
    d = (a >= b) ? (EXT_W'(a) - EXT_W'(b)) : (EXT_W'(b) - EXT_W'(a));
    return d[COORD_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] magnitude(logic signed [COORD_W-1:0] a);
    logic signed [EXT_W-1:0] e;
    e = EXT_W'(a);
    if (a < 0) e = -e;
    return e[COORD_W-1:0];
  endfunction

  // Bulge on the minor axis: positive when both ends sit on zero, otherwise
  // signed by whichever end lies farther from zero (the start on a tie).
  function automatic ext_coord_t bulge(logic signed [COORD_W-1:0] a0,
                                       logic signed [COORD_W-1:0] ag,
                                       logic [COORD_W-1:0] m0,
                                       logic [COORD_W-1:0] mg,
                                       logic signed [COORD_W-1:0] side);
    ext_coord_t pos;
    logic       neg_side;
    pos = EXT_W'(side);
    if (a0 == 0 && ag == 0) neg_side = 1'b0;
    else if (m0 >= mg)      neg_side = a0[COORD_W-1];
    else                    neg_side = ag[COORD_W-1];
    return neg_side ? -pos : pos;
  endfunction

  function automatic ext_coord_t midpoint(logic signed [COORD_W-1:0] a,
                                          logic signed [COORD_W-1:0] b);
    ext_coord_t s;
    s = EXT_W'(a) + EXT_W'(b);
    return s >>> 1;
  endfunction

  logic                      v1;
  logic                      en1;
  logic signed [COORD_W-1:0] sx, sy, sz, gx, gy, gz;
  logic        [COORD_W-1:0] adx, ady, mx0, mxg, my0, myg;
  logic                      x_major;

  assign en1        = !v1 || push_ready;
  assign in_ready   = en1;
  assign push_valid = v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      sx  <= $signed(in_data[0*COORD_W +: COORD_W]);
      sy  <= $signed(in_data[1*COORD_W +: COORD_W]);
      sz  <= $signed(in_data[2*COORD_W +: COORD_W]);
      gx  <= $signed(in_data[3*COORD_W +: COORD_W]);
      gy  <= $signed(in_data[4*COORD_W +: COORD_W]);
      gz  <= $signed(in_data[5*COORD_W +: COORD_W]);
      adx <= abs_diff($signed(in_data[0*COORD_W +: COORD_W]),
                      $signed(in_data[3*COORD_W +: COORD_W]));
      ady <= abs_diff($signed(in_data[1*COORD_W +: COORD_W]),
                      $signed(in_data[4*COORD_W +: COORD_W]));
      mx0 <= magnitude($signed(in_data[0*COORD_W +: COORD_W]));
      mxg <= magnitude($signed(in_data[3*COORD_W +: COORD_W]));
      my0 <= magnitude($signed(in_data[1*COORD_W +: COORD_W]));
      myg <= magnitude($signed(in_data[4*COORD_W +: COORD_W]));
    end
  end

  // With more travel along x the bulge goes along y, and the other way round.
  assign x_major = (adx >= ady);

  always_comb begin
    push_desc.p0x = EXT_W'(sx);
    push_desc.p0y = EXT_W'(sy);
    push_desc.p0z = EXT_W'(sz);
    push_desc.pgx = EXT_W'(gx);
    push_desc.pgy = EXT_W'(gy);
    push_desc.pgz = EXT_W'(gz);
    push_desc.p1z = EXT_W'(height_ext);
    if (x_major) begin
      push_desc.p1x = midpoint(sx, gx);
      push_desc.p1y = bulge(sy, gy, my0, myg, side_ext);
    end else begin
      push_desc.p1x = bulge(sx, gx, mx0, mxg, side_ext);
      push_desc.p1y = midpoint(sy, gy);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cbwg_back.sv @@
// Curve engine: steps t and evaluates one Bezier waypoint per cycle unless stalled.
`default_nettype none
`include "assert_macros.svh"

module cbwg_back
  import cbwg_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
  input  wire                    clk,
  input  wire                    rst,
  input  wire  [STEP_W-1:0]      step,
  input  wire                    q_valid,
  input  desc_t                  q_desc,
  output logic                   q_pop,
  output logic                   m_tvalid,
  input  wire                    m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata,
  output logic                   m_tlast
);

  localparam int F   = FRAC_BITS;
  localparam int WT  = F + 1;
  localparam int SQW = 2 * WT;
  localparam int WS  = F + 3;
  localparam int PW  = EXT_W + WS;
  localparam int SW  = PW + 2;
  localparam int TW  = ((WT > STEP_W) ? WT : STEP_W) + 1;
  localparam int NW  = $clog2(MAX_POINTS);

  localparam logic [WT-1:0]        ONE     = WT'(1) << F;
  localparam logic [SQW-1:0]       HALF_SQ = SQW'(1) << (F - 1);
  localparam logic signed [SW-1:0] HALF_S  = SW'(1) << (F - 1);

  // Whole pipeline stalls together behind the output register.
  logic en;
  assign en = !m_tvalid || m_tready;

  // Sequencer: t of the last issued point and the count of curve points.
  logic [WT-1:0] t_acc;
  logic [NW-1:0] n;
  logic [TW-1:0] cand;
  logic          more;
  logic          issue;

  assign issue = en && q_valid;
  assign cand  = TW'(t_acc) + TW'(step);
  assign more  = (n < NW'(MAX_POINTS - 1)) && (cand <= TW'(ONE));
  assign q_pop = issue && !more;

  logic v0, v1, v2, v3, v4, v5;
  logic last0, last1, last2, last3, last4, last5;
  logic [WT-1:0] t0, u0, t1, u1;
  desc_t desc0, desc1, desc2, desc3;
  logic [SQW-1:0] sqt1, squ1, cbt2, cbu2;
  logic [WT-1:0]  w0_3, w3_3;
  logic signed [WS-1:0] w1_3;
  logic signed [PW-1:0] prod4 [3][3];
  logic signed [SW-1:0] sum5 [3];

  logic [WT-1:0]        st2, su2, w0_n, w3_n;
  logic signed [WS-1:0] w0s, w1s, w3s;
  ext_coord_t           p0c [3];
  ext_coord_t           p1c [3];
  ext_coord_t           pgc [3];
  logic signed [SW-1:0] rnd_o [3];
  logic [COORD_W-1:0]   sat_o [3];

  always_comb begin
    st2  = WT'((sqt1 + HALF_SQ) >> F);
    su2  = WT'((squ1 + HALF_SQ) >> F);
    w3_n = WT'((cbt2 + HALF_SQ) >> F);
    w0_n = WT'((cbu2 + HALF_SQ) >> F);
    w0s  = $signed(WS'(w0_3));
    w3s  = $signed(WS'(w3_3));
    w1s  = w1_3;
    p0c[0] = desc3.p0x;  p1c[0] = desc3.p1x;  pgc[0] = desc3.pgx;
    p0c[1] = desc3.p0y;  p1c[1] = desc3.p1y;  pgc[1] = desc3.pgy;
    p0c[2] = desc3.p0z;  p1c[2] = desc3.p1z;  pgc[2] = desc3.pgz;
    for (int a = 0; a < 3; a++) begin
      rnd_o[a] = (sum5[a] + HALF_S) >>> F;
      if (rnd_o[a][SW-1:COORD_W-1] == '0 || rnd_o[a][SW-1:COORD_W-1] == '1) begin
        sat_o[a] = rnd_o[a][COORD_W-1:0];
      end else if (rnd_o[a][SW-1]) begin
        sat_o[a] = {1'b1, {(COORD_W - 1){1'b0}}};
      end else begin
        sat_o[a] = {1'b0, {(COORD_W - 1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_acc    <= '0;
      n        <= '0;
      v0       <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      v5       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v0       <= q_valid;
      v1       <= v0;
      v2       <= v1;
      v3       <= v2;
      v4       <= v3;
      v5       <= v4;
      m_tvalid <= v5;
      if (issue) begin
        if (more) begin
          t_acc <= cand[WT-1:0];
          n     <= n + NW'(1);
        end else begin
          t_acc <= '0;
          n     <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Issue: the goal point is the curve at t = 1, which is exact.
      if (more) begin
        t0    <= cand[WT-1:0];
        u0    <= ONE - cand[WT-1:0];
        last0 <= 1'b0;
      end else begin
        t0    <= ONE;
        u0    <= '0;
        last0 <= 1'b1;
      end
      desc0 <= q_desc;

      sqt1  <= t0 * t0;
      squ1  <= u0 * u0;
      t1    <= t0;
      u1    <= u0;
      last1 <= last0;
      desc1 <= desc0;

      cbt2  <= st2 * t1;
      cbu2  <= su2 * u1;
      last2 <= last1;
      desc2 <= desc1;

      w0_3  <= w0_n;
      w3_3  <= w3_n;
      w1_3  <= $signed(WS'(ONE)) - $signed(WS'(w0_n)) - $signed(WS'(w3_n));
      last3 <= last2;
      desc3 <= desc2;

      for (int a = 0; a < 3; a++) begin
        prod4[a][0] <= p0c[a] * w0s;
        prod4[a][1] <= p1c[a] * w1s;
        prod4[a][2] <= pgc[a] * w3s;
      end
      last4 <= last3;

      for (int a = 0; a < 3; a++) begin
        sum5[a] <= SW'(prod4[a][0]) + SW'(prod4[a][1]) + SW'(prod4[a][2]);
      end
      last5 <= last4;

      m_tdata <= {sat_o[2], sat_o[1], sat_o[0]};
      m_tlast <= last5;
    end
  end

  `CBWG_ASSERT_IMPLY(a_t_in_range, v0, t0 <= ONE, "issued t beyond one")
  `CBWG_ASSERT_IMPLY(a_last_at_one, v0 && last0, t0 == ONE && u0 == '0,
                     "goal point not issued at t equal to one")
  `CBWG_ASSERT_IMPLY(a_pop_needs_head, q_pop, q_valid, "queue popped while empty")

endmodule

`default_nettype wire

@@ rtl/core/cubic_bezier_waypoint_generator.sv @@
// Top level of the cubic Bezier waypoint generator.
//
// A request item on the s_ channel carries a start and a goal point in signed
// fixed point. The block picks one inner control point, bulging along the axis
// of smaller travel by side_extension at height height_extension, and streams
// waypoints on the m_ channel at t = step, 2*step, ... while t stays at or
// below one (at most MAX_POINTS-1 of them), followed by the goal itself with
// m_tlast high. The cfg_ channel writes step_fraction, side_extension and
// height_extension and is always ready; write it only while the block is idle.
// A request passes the classifier register, the queue and the curve engine
// pipeline, whose output register drives the m_ channel. The curve engine
// issues one waypoint per cycle unless m_tready stalls it; a request yields
// N+1 of them, N = min(floor(one/step), MAX_POINTS-1), at most MAX_POINTS,
// and the next request in the queue follows with no gap. The two-entry
// queue lets the next requests be taken while a curve is still streaming.
// Reset clears every pipeline and queue valid bit and loads the default
// configuration. When m_tready is low the whole curve pipeline holds its
// contents, the queue and classifier register fill, and then s_tready drops.
`default_nettype none

module cubic_bezier_waypoint_generator
  import cbwg_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
  input  wire                    clk,
  input  wire                    rst,
  // Request: start_x, start_y, start_z, goal_x, goal_y, goal_z (lowest first).
  input  wire                    s_tvalid,
  output logic                   s_tready,
  input  wire  [IN_DATA_W-1:0]   s_tdata,
  // Waypoint: point_x, point_y, point_z (lowest first); last_point on m_tlast.
  output logic                   m_tvalid,
  input  wire                    m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata,
  output logic                   m_tlast,
  // Configuration writes: index 0 step, 1 side extension, 2 height extension.
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire  [IDX_W-1:0]       cfg_index,
  input  wire  [COORD_W-1:0]     cfg_data
);

  logic [STEP_W-1:0]         step_fraction;
  logic signed [COORD_W-1:0] side_extension;
  logic signed [COORD_W-1:0] height_extension;

  assign cfg_ready = 1'b1;

  // Writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_fraction    <= STEP_RESET;
      side_extension   <= SIDE_RESET;
      height_extension <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STEP:   step_fraction    <= cfg_data[STEP_W-1:0];
        REG_SIDE:   side_extension   <= $signed(cfg_data);
        REG_HEIGHT: height_extension <= $signed(cfg_data);
        default:    ;
      endcase
    end
  end

  logic  push_valid;
  logic  push_ready;
  desc_t push_desc;
  logic  head_valid;
  desc_t head_desc;
  logic  pop;

  cbwg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_data    (s_tdata),
    .side_ext   (side_extension),
    .height_ext (height_extension),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc)
  );

  cbwg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop)
  );

  cbwg_back #(
    .MAX_POINTS (MAX_POINTS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .step     (step_fraction),
    .q_valid  (head_valid),
    .q_desc   (head_desc),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire
